### src/mrpw_pkg.sv
`timescale 1ns / 1ps

package mrpw_pkg;

    // Default grid size.
    localparam int DEF_COLS = 16;
    localparam int DEF_ROWS = 16;

    // Result queue depth: covers the read stage plus one result waiting at the output.
    localparam int OUT_FIFO_DEPTH = 3;

    // Stream data widths, rounded up to whole bytes.
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 24;

    // Command codes.
    typedef enum logic [1:0] {
        OP_SENSE   = 2'd0,
        OP_FORWARD = 2'd1,
        OP_RIGHT   = 2'd2,
        OP_LEFT    = 2'd3
    } t_op;

    // Robot heading.
    typedef enum logic [1:0] {
        DIR_NORTH = 2'd0,
        DIR_EAST  = 2'd1,
        DIR_SOUTH = 2'd2,
        DIR_WEST  = 2'd3
    } t_dir;

    // Map initialisation sweep, then normal running.
    typedef enum logic {
        MODE_CLEAR = 1'b0,
        MODE_RUN   = 1'b1
    } t_mode;

    // One result, last field in the lowest bits.
    typedef struct packed {
        logic       probe_explored;
        logic       probe_west;
        logic       probe_south;
        logic       probe_east;
        logic       probe_north;
        logic       at_start;
        logic       at_centre;
        logic [1:0] heading;
        logic [3:0] cur_y;
        logic [3:0] cur_x;
    } t_result;

    localparam int RESULT_W = $bits(t_result);

endpackage

### src/mrpw_bit_mem.sv
`timescale 1ns / 1ps

module mrpw_bit_mem #(
    parameter int AW = 8
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic          i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic          o_rdata
);

    localparam int DEPTH = 1 << AW;

    logic r_mem [DEPTH];
    logic r_rdata;

    // Single-bit RAM, one write and one read port, write-first on an address match.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= (i_we && (i_waddr == i_raddr)) ? i_wdata : r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### src/mrpw_out_fifo.sv
`timescale 1ns / 1ps

module mrpw_out_fifo import mrpw_pkg::*; #(
    parameter int DEPTH = OUT_FIFO_DEPTH,
    localparam int CNTW = $clog2(DEPTH + 1)
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  t_result         i_data,
    output logic [CNTW-1:0] o_count,
    output logic            o_valid,
    input  logic            i_ready,
    output t_result         o_data
);

    localparam int PTRW = $clog2(DEPTH);

    t_result          r_mem [DEPTH];
    logic [PTRW-1:0]  r_wptr;
    logic [PTRW-1:0]  r_rptr;
    logic [CNTW-1:0]  r_count;
    logic [PTRW-1:0]  n_wptr;
    logic [PTRW-1:0]  n_rptr;
    logic [CNTW-1:0]  n_count;
    logic             pop;

    assign pop = o_valid && i_ready;

    // Pointer and fill count update.
    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_push) begin
            n_wptr = (r_wptr == PTRW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (pop) begin
            n_rptr = (r_rptr == PTRW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (i_push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    // Result storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    assign o_count = r_count;
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rptr];

    // A result must never arrive at a full queue.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_count < CNTW'(DEPTH)))
        else $error("result queue overflow");

    // A pop without a push frees exactly one entry.
    a_pop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !i_push) |=> (r_count == $past(r_count) - 1'b1))
        else $error("result queue count wrong after pop");

endmodule

### src/maze_robot_pose_and_wall_map.sv
`timescale 1ns / 1ps

// A result passes through the read stage and the result queue before it is offered.
// Throughput: one command per cycle while the queue has room and no sweep runs; the five wall
// and explored bit memories each take one read per command and one write per sense command,
// walls stored once per shared edge. Reset: synchronous, active low; pose returns to column 0,
// row 0, facing north, then all 2**SW map addresses (256 for 16x16) are set up, no input taken.
module maze_robot_pose_and_wall_map import mrpw_pkg::*; #(
    parameter int COLS = DEF_COLS,
    parameter int ROWS = DEF_ROWS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // opcode[1:0], seen_north[2], seen_east[3], seen_south[4], seen_west[5],
    // probe_x[9:6], probe_y[13:10], zero [15:14]
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // cur_x[3:0], cur_y[7:4], heading[9:8], at_centre[10], at_start[11], probe_north[12],
    // probe_east[13], probe_south[14], probe_west[15], probe_explored[16], zero [23:17]
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata
);

    // Cell coordinates and edge coordinates (edges run one past the last cell).
    localparam int PCW = $clog2(COLS);
    localparam int PRW = $clog2(ROWS);
    localparam int CW  = $clog2(COLS + 1);
    localparam int RW  = $clog2(ROWS + 1);
    // Horizontal walls split by row parity, vertical walls by column parity.
    localparam int HAW = RW - 1 + PCW;
    localparam int VAW = CW - 1 + PRW;
    localparam int XAW = PRW + PCW;
    localparam int SW  = (HAW > VAW) ? ((HAW > XAW) ? HAW : XAW) : ((VAW > XAW) ? VAW : XAW);
    localparam int QCW = $clog2(OUT_FIFO_DEPTH + 1);

    localparam logic [PRW-1:0] ROW_LAST = PRW'(ROWS - 1);
    localparam logic [PCW-1:0] COL_LAST = PCW'(COLS - 1);
    localparam logic [RW-1:0]  ROW_TOP  = RW'(ROWS);
    localparam logic [CW-1:0]  COL_END  = CW'(COLS);
    localparam logic [CW-1:0]  COL_ONE  = CW'(1);
    localparam logic [PCW-1:0] CEN_C0   = PCW'((COLS - 1) / 2);
    localparam logic [PCW-1:0] CEN_C1   = PCW'(COLS / 2);
    localparam logic [PRW-1:0] CEN_R0   = PRW'((ROWS - 1) / 2);
    localparam logic [PRW-1:0] CEN_R1   = PRW'(ROWS / 2);

    // Control and pose.
    t_mode            r_mode;
    t_mode            n_mode;
    logic [SW-1:0]    r_sweep;
    logic [SW-1:0]    n_sweep;
    logic [PCW-1:0]   r_col;
    logic [PCW-1:0]   n_col;
    logic [PRW-1:0]   r_row;
    logic [PRW-1:0]   n_row;
    t_dir             r_head;
    t_dir             n_head;

    // Read stage.
    logic             r_b_valid;
    logic             r_b_in_range;
    logic             r_b_px0;
    logic             r_b_py0;

    // Decoded request.
    t_op              in_op;
    logic             in_n;
    logic             in_e;
    logic             in_s;
    logic             in_w;
    logic [3:0]       in_px;
    logic [3:0]       in_py;
    logic             accept;
    logic             clearing;
    logic             sense_wr;

    // Command write targets.
    logic [RW-1:0]    row_s;
    logic [RW-1:0]    row_n;
    logic [RW-1:0]    he_row;
    logic [RW-1:0]    ho_row;
    logic             he_dat;
    logic             ho_dat;
    logic [CW-1:0]    col_w;
    logic [CW-1:0]    col_e;
    logic [CW-1:0]    ve_col;
    logic [CW-1:0]    vo_col;
    logic             ve_dat;
    logic             vo_dat;

    // Initialisation values.
    logic [HAW-1:0]   clr_h_addr;
    logic [VAW-1:0]   clr_v_addr;
    logic [XAW-1:0]   clr_x_addr;
    logic [RW-1:0]    clr_he_row;
    logic [RW-1:0]    clr_ho_row;
    logic [CW-1:0]    clr_ve_col;
    logic [CW-1:0]    clr_vo_col;

    // Probe read targets.
    logic [PCW-1:0]   p_col;
    logic [PRW-1:0]   p_row;
    logic [RW-1:0]    p_rs;
    logic [RW-1:0]    p_rn;
    logic [RW-1:0]    p_he_row;
    logic [RW-1:0]    p_ho_row;
    logic [CW-1:0]    p_cw;
    logic [CW-1:0]    p_ce;
    logic [CW-1:0]    p_ve_col;
    logic [CW-1:0]    p_vo_col;
    logic             p_in_range;

    // Memory ports.
    logic             he_we;
    logic             ho_we;
    logic             ve_we;
    logic             vo_we;
    logic             x_we;
    logic [HAW-1:0]   he_waddr;
    logic [HAW-1:0]   ho_waddr;
    logic [VAW-1:0]   ve_waddr;
    logic [VAW-1:0]   vo_waddr;
    logic [XAW-1:0]   x_waddr;
    logic             he_wdata;
    logic             ho_wdata;
    logic             ve_wdata;
    logic             vo_wdata;
    logic             x_wdata;
    logic [HAW-1:0]   he_raddr;
    logic [HAW-1:0]   ho_raddr;
    logic [VAW-1:0]   ve_raddr;
    logic [VAW-1:0]   vo_raddr;
    logic [XAW-1:0]   x_raddr;
    logic             he_rdata;
    logic             ho_rdata;
    logic             ve_rdata;
    logic             vo_rdata;
    logic             x_rdata;

    // Result path.
    t_result          b_result;
    t_result          q_result;
    logic [QCW-1:0]   q_count;

    // Request decode.
    assign in_op  = t_op'(i_s_axis_tdata[1:0]);
    assign in_n   = i_s_axis_tdata[2];
    assign in_e   = i_s_axis_tdata[3];
    assign in_s   = i_s_axis_tdata[4];
    assign in_w   = i_s_axis_tdata[5];
    assign in_px  = i_s_axis_tdata[9:6];
    assign in_py  = i_s_axis_tdata[13:10];

    assign clearing = (r_mode == MODE_CLEAR);
    assign o_s_axis_tready = !clearing &&
        ((QCW + 1)'(q_count) + (QCW + 1)'(r_b_valid) < (QCW + 1)'(OUT_FIFO_DEPTH));
    assign accept   = i_s_axis_tvalid && o_s_axis_tready;
    assign sense_wr = accept && (in_op == OP_SENSE);

    // Initialisation sweep sequencing.
    always_comb begin
        n_mode  = r_mode;
        n_sweep = r_sweep;
        unique case (r_mode)
            MODE_CLEAR: begin
                n_sweep = r_sweep + 1'b1;
                if (r_sweep == '1) begin
                    n_mode = MODE_RUN;
                end
            end
            MODE_RUN: begin
                n_sweep = r_sweep;
            end
            default: begin
                n_mode = MODE_CLEAR;
            end
        endcase
    end

    // Pose update; forward moves trust the walls seen in the request.
    always_comb begin
        n_col  = r_col;
        n_row  = r_row;
        n_head = r_head;
        if (accept) begin
            unique case (in_op)
                OP_SENSE: begin
                    n_head = r_head;
                end
                OP_FORWARD: begin
                    unique case (r_head)
                        DIR_NORTH: if (!in_n && (r_row != ROW_LAST)) n_row = r_row + 1'b1;
                        DIR_EAST:  if (!in_e && (r_col != COL_LAST)) n_col = r_col + 1'b1;
                        DIR_SOUTH: if (!in_s && (r_row != '0))       n_row = r_row - 1'b1;
                        DIR_WEST:  if (!in_w && (r_col != '0))       n_col = r_col - 1'b1;
                        default:   n_head = r_head;
                    endcase
                end
                OP_RIGHT: n_head = t_dir'(r_head + 2'd1);
                OP_LEFT:  n_head = t_dir'(r_head - 2'd1);
                default:  n_head = r_head;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_CLEAR;
            r_sweep   <= '0;
            r_col     <= '0;
            r_row     <= '0;
            r_head    <= DIR_NORTH;
            r_b_valid <= 1'b0;
        end else begin
            r_mode    <= n_mode;
            r_sweep   <= n_sweep;
            r_col     <= n_col;
            r_row     <= n_row;
            r_head    <= n_head;
            r_b_valid <= accept;
        end
    end

    // Probe details carried alongside the memory read.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_b_in_range <= p_in_range;
            r_b_px0      <= p_col[0];
            r_b_py0      <= p_row[0];
        end
    end

    // Sense writes: south edge of this row and the edge above it land in opposite parity
    // banks, as do the west edge and the edge to the east.
    always_comb begin
        row_s  = RW'(r_row);
        row_n  = row_s + 1'b1;
        he_row = r_row[0] ? row_n : row_s;
        he_dat = r_row[0] ? in_n  : in_s;
        ho_row = r_row[0] ? row_s : row_n;
        ho_dat = r_row[0] ? in_s  : in_n;
        col_w  = CW'(r_col);
        col_e  = col_w + 1'b1;
        ve_col = r_col[0] ? col_e : col_w;
        ve_dat = r_col[0] ? in_e  : in_w;
        vo_col = r_col[0] ? col_w : col_e;
        vo_dat = r_col[0] ? in_w  : in_e;
    end

    // Initial map: grid border walls plus the wall east of the start cell.
    always_comb begin
        clr_h_addr = r_sweep[HAW-1:0];
        clr_v_addr = r_sweep[VAW-1:0];
        clr_x_addr = r_sweep[XAW-1:0];
        clr_he_row = {clr_h_addr[HAW-1:PCW], 1'b0};
        clr_ho_row = {clr_h_addr[HAW-1:PCW], 1'b1};
        clr_ve_col = {clr_v_addr[VAW-1:PRW], 1'b0};
        clr_vo_col = {clr_v_addr[VAW-1:PRW], 1'b1};
    end

    // Write port selection.
    always_comb begin
        if (clearing) begin
            he_we    = 1'b1;
            ho_we    = 1'b1;
            ve_we    = 1'b1;
            vo_we    = 1'b1;
            x_we     = 1'b1;
            he_waddr = clr_h_addr;
            ho_waddr = clr_h_addr;
            ve_waddr = clr_v_addr;
            vo_waddr = clr_v_addr;
            x_waddr  = clr_x_addr;
            he_wdata = (clr_he_row == '0) || (clr_he_row == ROW_TOP);
            ho_wdata = (clr_ho_row == ROW_TOP);
            ve_wdata = (clr_ve_col == '0) || (clr_ve_col == COL_END);
            vo_wdata = (clr_vo_col == COL_END) ||
                       ((clr_vo_col == COL_ONE) && (clr_v_addr[PRW-1:0] == '0));
            x_wdata  = 1'b0;
        end else begin
            he_we    = sense_wr;
            ho_we    = sense_wr;
            ve_we    = sense_wr;
            vo_we    = sense_wr;
            x_we     = sense_wr;
            he_waddr = {he_row[RW-1:1], r_col};
            ho_waddr = {ho_row[RW-1:1], r_col};
            ve_waddr = {ve_col[CW-1:1], r_row};
            vo_waddr = {vo_col[CW-1:1], r_row};
            x_waddr  = {r_row, r_col};
            he_wdata = he_dat;
            ho_wdata = ho_dat;
            ve_wdata = ve_dat;
            vo_wdata = vo_dat;
            x_wdata  = 1'b1;
        end
    end

    // Probe reads; the memories return this cycle's write on a matching address.
    always_comb begin
        p_in_range = (int'(in_px) < COLS) && (int'(in_py) < ROWS);
        p_col      = PCW'(in_px);
        p_row      = PRW'(in_py);
        p_rs       = RW'(p_row);
        p_rn       = p_rs + 1'b1;
        p_he_row   = p_row[0] ? p_rn : p_rs;
        p_ho_row   = p_row[0] ? p_rs : p_rn;
        p_cw       = CW'(p_col);
        p_ce       = p_cw + 1'b1;
        p_ve_col   = p_col[0] ? p_ce : p_cw;
        p_vo_col   = p_col[0] ? p_cw : p_ce;
        he_raddr   = {p_he_row[RW-1:1], p_col};
        ho_raddr   = {p_ho_row[RW-1:1], p_col};
        ve_raddr   = {p_ve_col[CW-1:1], p_row};
        vo_raddr   = {p_vo_col[CW-1:1], p_row};
        x_raddr    = {p_row, p_col};
    end

    mrpw_bit_mem #(.AW(HAW)) u_h_even (
        .i_clk  (i_clk),
        .i_we   (he_we),
        .i_waddr(he_waddr),
        .i_wdata(he_wdata),
        .i_raddr(he_raddr),
        .o_rdata(he_rdata)
    );

    mrpw_bit_mem #(.AW(HAW)) u_h_odd (
        .i_clk  (i_clk),
        .i_we   (ho_we),
        .i_waddr(ho_waddr),
        .i_wdata(ho_wdata),
        .i_raddr(ho_raddr),
        .o_rdata(ho_rdata)
    );

    mrpw_bit_mem #(.AW(VAW)) u_v_even (
        .i_clk  (i_clk),
        .i_we   (ve_we),
        .i_waddr(ve_waddr),
        .i_wdata(ve_wdata),
        .i_raddr(ve_raddr),
        .o_rdata(ve_rdata)
    );

    mrpw_bit_mem #(.AW(VAW)) u_v_odd (
        .i_clk  (i_clk),
        .i_we   (vo_we),
        .i_waddr(vo_waddr),
        .i_wdata(vo_wdata),
        .i_raddr(vo_raddr),
        .o_rdata(vo_rdata)
    );

    mrpw_bit_mem #(.AW(XAW)) u_explored (
        .i_clk  (i_clk),
        .i_we   (x_we),
        .i_waddr(x_waddr),
        .i_wdata(x_wdata),
        .i_raddr(x_raddr),
        .o_rdata(x_rdata)
    );

    // Result assembly; the pose registers already hold this command's outcome.
    always_comb begin
        b_result.cur_x          = 4'(r_col);
        b_result.cur_y          = 4'(r_row);
        b_result.heading        = r_head;
        b_result.at_centre      = ((r_col == CEN_C0) || (r_col == CEN_C1)) &&
                                  ((r_row == CEN_R0) || (r_row == CEN_R1));
        b_result.at_start       = (r_col == '0) && (r_row == '0);
        b_result.probe_north    = r_b_in_range && (r_b_py0 ? he_rdata : ho_rdata);
        b_result.probe_south    = r_b_in_range && (r_b_py0 ? ho_rdata : he_rdata);
        b_result.probe_east     = r_b_in_range && (r_b_px0 ? ve_rdata : vo_rdata);
        b_result.probe_west     = r_b_in_range && (r_b_px0 ? vo_rdata : ve_rdata);
        b_result.probe_explored = r_b_in_range && x_rdata;
    end

    mrpw_out_fifo #(.DEPTH(OUT_FIFO_DEPTH)) u_out_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (r_b_valid),
        .i_data (b_result),
        .o_count(q_count),
        .o_valid(o_m_axis_tvalid),
        .i_ready(i_m_axis_tready),
        .o_data (q_result)
    );

    assign o_m_axis_tdata = {(OUT_TDATA_W - RESULT_W)'(0), q_result};

    // Only a forward command may move the robot.
    a_move_only_forward: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (in_op != OP_FORWARD)) |=> ($stable(r_col) && $stable(r_row)))
        else $error("position changed on a non-forward command");

    // Only turns change the heading.
    a_head_only_turn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && ((in_op == OP_SENSE) || (in_op == OP_FORWARD))) |=> $stable(r_head))
        else $error("heading changed on a sense or forward command");

    // A forward step moves along one axis at most.
    a_single_axis: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (in_op == OP_FORWARD)) |=> ($stable(r_col) || $stable(r_row)))
        else $error("forward step moved along both axes");

    // Nothing is in flight while the map is being initialised.
    a_idle_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clearing |-> (!r_b_valid && (q_count == '0)))
        else $error("request in flight during map initialisation");

endmodule
